// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/fsc_pkg.sv =====
`default_nettype none
package fsc_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NORM_FRAC       = 30;
    localparam int NUM_PLANES      = 6;
    localparam int NUM_CORNERS     = 8;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BUILD = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_OUT,
        ST_B_RD, ST_B_P1, ST_B_P2, ST_B_P3, ST_B_UV, ST_B_MUL, ST_B_CRS,
        ST_B_NRM, ST_B_SQ, ST_B_SQS, ST_B_SQRT, ST_B_DIV, ST_B_DOT, ST_B_DOTS,
        ST_B_WR,
        ST_T_RD, ST_T_MUL, ST_T_ACC
    } state_t;

    // corner triple (P1,P2,P3) of a plane
    function automatic logic [2:0] plane_corner(input logic [2:0] pl, input logic [1:0] k);
        logic [8:0] t;
        case (pl)
            3'd0: t = {3'd6, 3'd5, 3'd1};
            3'd1: t = {3'd3, 3'd0, 3'd4};
            3'd2: t = {3'd1, 3'd5, 3'd4};
            3'd3: t = {3'd6, 3'd2, 3'd3};
            3'd4: t = {3'd7, 3'd4, 3'd5};
            3'd5: t = {3'd2, 3'd1, 3'd0};
            default: t = '0;
        endcase
        case (k)
            2'd0: plane_corner = t[2:0];
            2'd1: plane_corner = t[5:3];
            default: plane_corner = t[8:6];
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/frustum_sphere_cull.sv =====
// Sphere versus view-frustum cull. Each input transfer is a load (writes one
// corner), a build (forms all six planes from the stored corners), a test
// (sphere against the planes) or a no-op; every transfer yields exactly one
// result. Corners and planes sit in two single-port-read synchronous RAMs
// with registered reads. Input is taken only in idle, one item at a time.
// A load writes its corner one coordinate at a time in the output state. A
// test runs six planes of four coefficients, each through plane RAM read,
// shared multiplier and accumulate, then outputs its result. A build's time
// per plane is set by the 32-step square root and the 62-step divider that
// normalize each normal, plus shifting the normal into range; a degenerate
// plane skips the square root and the divider. The result register frees
// the input side: the next item can be taken while a result waits, and the
// block stalls on its last cycle only if the previous result has still not
// left. Building from a corner never loaded is undefined.
`default_nettype none
module frustum_sphere_cull #(
    parameter int FRAC_BITS   = fsc_pkg::FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: corner_index[2:0], point_x[34:3], point_y[66:35], point_z[98:67],
    //        radius[129:99], zero fill [135:130]
    input  wire logic [135:0] s_tdata,
    input  wire logic [1:0]   s_tuser,   // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // inside_res[0], zero fill [7:1]
    output logic              m_tuser    // is_test
);
    import fsc_pkg::*;
    `include "assert_macros.svh"

    localparam int CW  = COORD_WIDTH_DEF;
    localparam int PW  = 2 * CW + 2;          // product width
    localparam int MW  = 32;                  // cross-product magnitude width
    localparam int SW  = 64;                  // sum of squares width
    localparam int DW  = MW + NORM_FRAC;      // dividend width
    localparam int QW  = 32;

    state_t state_reg, state_next;

    // corner RAM: 24 entries of CW bits
    logic [CW-1:0] crn_mem [0:3*NUM_CORNERS-1];
    logic [4:0]    crn_addr;
    logic          crn_we;
    logic [CW-1:0] crn_wdata, crn_rdata;
    // plane RAM: 24 entries of 32 bits, with valid bits (reset all zero)
    logic [31:0]   pln_mem [0:4*NUM_PLANES-1];
    logic [23:0]   pln_vld_reg;
    logic [4:0]    pln_addr;
    logic          pln_we;
    logic [31:0]   pln_wdata, pln_rdata_raw, pln_rdata;
    logic          pln_rvld_reg;

    always_ff @(posedge aclk) begin
        if (crn_we) crn_mem[crn_addr] <= crn_wdata;
        crn_rdata <= crn_mem[crn_addr];
        if (pln_we) pln_mem[pln_addr] <= pln_wdata;
        pln_rdata_raw <= pln_mem[pln_addr];
    end
    assign pln_rdata = pln_rvld_reg ? pln_rdata_raw : 32'd0;

    // working registers
    logic [1:0]           act_reg;
    logic [2:0]           idx_reg;
    logic signed [CW-1:0] pt_reg [0:2];
    logic [30:0]          rad_reg;
    logic [2:0]           pl_reg;       // plane counter
    logic [1:0]           k_reg;        // corner/component counter
    logic [1:0]           j_reg;        // point select / sub-step
    logic signed [CW-1:0] p_reg [0:2][0:2];
    logic signed [CW-1:0] u_reg [0:2], v_reg [0:2], c_reg [0:2];
    logic signed [PW-1:0] prod_reg;
    logic signed [CW:0]   t1_reg;
    logic [MW-1:0]        m_reg [0:2];
    logic [SW-1:0]        sum_reg;
    logic [SW-1:0]        sq_x_reg, sq_bit_reg;
    logic [SW-1:0]        sq_res_reg;
    logic [DW-1:0]        dv_rem_reg;
    logic [DW-1:0]        dv_num_reg;
    logic [QW-1:0]        dv_q_reg;
    logic [6:0]           it_reg;
    logic signed [31:0]   n_reg [0:2];
    logic signed [66:0]   acc_reg;
    logic                 out_vld_reg, out_test_reg, out_in_reg, inside_reg;
    logic                 out_free;

    // shared multiplier operands (registered product)
    logic signed [CW:0]   mul_a, mul_b;
    logic [5:0]           mul_sh;

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi, lo;
        hi = PW'((64'sd1 <<< (CW - 1)) - 64'sd1);
        lo = -hi - PW'(1);
        if (v > hi) sat_cw = hi[CW-1:0];
        else if (v < lo) sat_cw = lo[CW-1:0];
        else sat_cw = v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_in(input logic [31:0] v);
        sat_in = sat_cw(PW'($signed(v)));
    endfunction

    logic [1:0]  s_act;
    assign s_act     = s_tuser;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = out_test_reg;
    assign m_tdata   = {7'd0, out_in_reg};
    assign out_free  = !out_vld_reg || m_tready;

    // shifted product floor(prod >> sh), arithmetic shift without saturation
    logic signed [PW-1:0] prod_sh;
    assign prod_sh = prod_reg >>> mul_sh;

    logic [MW-1:0] big;
    always_comb begin
        big = m_reg[0];
        if (m_reg[1] > big) big = m_reg[1];
        if (m_reg[2] > big) big = m_reg[2];
    end

    logic signed [CW-1:0] c_new;
    logic signed [PW-1:0] t2_s, diff_s;
    always_comb begin
        t2_s   = PW'(sat_cw(prod_sh));
        diff_s = PW'(t1_reg) - t2_s;
        c_new  = sat_cw(diff_s);
    end

    // magnitudes for the normalize step, which shifts them so big lands in [2^29, 2^30)
    logic [MW-1:0] mag [0:2];
    always_comb begin
        for (int i = 0; i < 3; i++)
            mag[i] = c_reg[i][CW-1] ? MW'(-PW'(c_reg[i])) : MW'(PW'(c_reg[i]));
    end

    always_comb begin
        state_next = state_reg;
        crn_we = 1'b0; crn_addr = 5'd0; crn_wdata = '0;
        pln_we = 1'b0; pln_addr = 5'd0; pln_wdata = '0;
        mul_a = '0; mul_b = '0; mul_sh = 6'd0;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) begin
                case (action_t'(s_act))
                    ACT_LOAD:  state_next = ST_OUT;
                    ACT_BUILD: state_next = ST_B_RD;
                    ACT_TEST:  state_next = ST_T_RD;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_OUT: begin
                // leave only when the result register can take the new result
                if (act_reg == ACT_LOAD) begin
                    crn_we    = 1'b1;
                    crn_addr  = 5'(idx_reg * 3 + j_reg);
                    crn_wdata = pt_reg[j_reg];
                    if (j_reg == 2'd2 && out_free) state_next = ST_IDLE;
                end else if (out_free) state_next = ST_IDLE;
            end
            ST_B_RD: begin
                crn_addr   = 5'(plane_corner(pl_reg, k_reg) * 3 + j_reg);
                state_next = ST_B_P1;
            end
            ST_B_P1: begin
                // crn_rdata valid for previous address; issue next read
                if (!(k_reg == 2'd2 && j_reg == 2'd2)) begin
                    if (j_reg == 2'd2)
                        crn_addr = 5'(plane_corner(pl_reg, k_reg + 2'd1) * 3);
                    else
                        crn_addr = 5'(plane_corner(pl_reg, k_reg) * 3 + j_reg + 2'd1);
                end else state_next = ST_B_UV;
            end
            ST_B_UV: state_next = ST_B_MUL;
            ST_B_MUL: begin
                // k_reg = component, j_reg = 0 first term, 1 second term
                case (k_reg)
                    2'd0: begin mul_a = (j_reg == 0) ? (CW+1)'(u_reg[1]) : (CW+1)'(u_reg[2]);
                                mul_b = (j_reg == 0) ? (CW+1)'(v_reg[2]) : (CW+1)'(v_reg[1]); end
                    2'd1: begin mul_a = (j_reg == 0) ? (CW+1)'(u_reg[2]) : (CW+1)'(u_reg[0]);
                                mul_b = (j_reg == 0) ? (CW+1)'(v_reg[0]) : (CW+1)'(v_reg[2]); end
                    default: begin mul_a = (j_reg == 0) ? (CW+1)'(u_reg[0]) : (CW+1)'(u_reg[1]);
                                mul_b = (j_reg == 0) ? (CW+1)'(v_reg[1]) : (CW+1)'(v_reg[0]); end
                endcase
                state_next = ST_B_CRS;
            end
            ST_B_CRS: begin
                mul_sh = 6'(FRAC_BITS);
                if (j_reg == 2'd1 && k_reg == 2'd2) state_next = ST_B_NRM;
                else state_next = ST_B_MUL;
            end
            ST_B_NRM: begin
                if (m_reg[0] == 0 && m_reg[1] == 0 && m_reg[2] == 0) state_next = ST_B_WR;
                else if (big >= MW'(1 << 30)) state_next = ST_B_NRM;
                else if (big < MW'(1 << 29)) state_next = ST_B_NRM;
                else state_next = ST_B_SQ;
            end
            ST_B_SQ: begin
                mul_a      = (CW+1)'(m_reg[j_reg]);
                mul_b      = (CW+1)'(m_reg[j_reg]);
                state_next = ST_B_SQS;
            end
            ST_B_SQS: state_next = (j_reg == 2'd2) ? ST_B_SQRT : ST_B_SQ;
            ST_B_SQRT: if (sq_bit_reg == 0) state_next = ST_B_DIV;
            ST_B_DIV: if (it_reg == 7'd0 && k_reg == 2'd2) state_next = ST_B_DOT;
            ST_B_DOT: begin
                mul_a = (CW+1)'(n_reg[j_reg]);
                mul_b = (CW+1)'(p_reg[0][j_reg]);
                state_next = ST_B_DOTS;
            end
            ST_B_DOTS: begin
                mul_sh = 6'(NORM_FRAC);
                state_next = (j_reg == 2'd2) ? ST_B_WR : ST_B_DOT;
            end
            ST_B_WR: begin
                pln_we    = 1'b1;
                pln_addr  = 5'(pl_reg * 4 + j_reg);
                if (j_reg == 2'd3) begin
                    if (acc_reg > 67'sd2147483647) pln_wdata = 32'h7fffffff;
                    else if (acc_reg < -67'sd2147483648) pln_wdata = 32'h80000000;
                    else pln_wdata = acc_reg[31:0];
                end else pln_wdata = n_reg[j_reg];
                if (j_reg == 2'd3)
                    state_next = (pl_reg == 3'd5) ? ST_OUT : ST_B_RD;
            end
            ST_T_RD: begin
                pln_addr   = 5'(pl_reg * 4 + k_reg);
                state_next = ST_T_MUL;
            end
            ST_T_MUL: begin
                // hold the address so d is still on the read port in ST_T_ACC
                pln_addr = 5'(pl_reg * 4 + k_reg);
                if (k_reg != 2'd3) begin
                    mul_a = (CW+1)'($signed(pln_rdata));
                    mul_b = (CW+1)'(pt_reg[k_reg]);
                end
                state_next = ST_T_ACC;
            end
            ST_T_ACC: begin
                mul_sh = 6'(NORM_FRAC);
                if (k_reg == 2'd3 && pl_reg == 3'd5) state_next = ST_OUT;
                else state_next = ST_T_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // test: plane coefficient 3 (d) is added without multiplier
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            pln_vld_reg  <= '0;
            pln_rvld_reg <= 1'b0;
        end else begin
            pln_rvld_reg <= pln_vld_reg[pln_addr];
            if (pln_we) pln_vld_reg[pln_addr] <= 1'b1;
            if (state_reg == ST_OUT && state_next == ST_IDLE) begin
                out_vld_reg  <= 1'b1;
                out_test_reg <= (act_reg == ACT_TEST);
                out_in_reg   <= (act_reg == ACT_TEST) && inside_reg;
            end else if (out_vld_reg && m_tready) out_vld_reg <= 1'b0;
        end
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) begin
                act_reg   <= s_act;
                idx_reg   <= s_tdata[2:0];
                pt_reg[0] <= sat_in(s_tdata[34:3]);
                pt_reg[1] <= sat_in(s_tdata[66:35]);
                pt_reg[2] <= sat_in(s_tdata[98:67]);
                rad_reg   <= s_tdata[129:99];
                pl_reg    <= '0;
                k_reg     <= '0;
                j_reg     <= '0;
                acc_reg   <= '0;
                inside_reg <= 1'b1;
            end
            ST_OUT: if (j_reg != 2'd2) j_reg <= j_reg + 2'd1;
            ST_B_RD: begin k_reg <= '0; j_reg <= '0; end
            ST_B_P1: begin
                p_reg[k_reg][j_reg] <= crn_rdata;
                if (j_reg == 2'd2) begin j_reg <= '0; k_reg <= k_reg + 2'd1; end
                else j_reg <= j_reg + 2'd1;
            end
            ST_B_UV: begin
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= sat_cw(PW'(p_reg[0][i]) - PW'(p_reg[1][i]));
                    v_reg[i] <= sat_cw(PW'(p_reg[0][i]) - PW'(p_reg[2][i]));
                end
                k_reg <= '0; j_reg <= '0;
            end
            ST_B_CRS: begin
                if (j_reg == 2'd0) begin
                    t1_reg <= (CW+1)'(sat_cw(prod_sh));
                    j_reg  <= 2'd1;
                end else begin
                    c_reg[k_reg] <= c_new;
                    j_reg <= 2'd0;
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        for (int i = 0; i < 3; i++)
                            m_reg[i] <= (i == 2) ?
                                (c_new[CW-1] ? MW'(-PW'(c_new)) : MW'(PW'(c_new))) : mag[i];
                    end
                end
            end
            ST_B_NRM: begin
                if (big >= MW'(1 << 30))
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] >> 1;
                else if (big < MW'(1 << 29) && big != 0)
                    for (int i = 0; i < 3; i++) m_reg[i] <= m_reg[i] << 1;
                sum_reg <= '0; j_reg <= '0;
                if (big == 0) begin
                    for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                    acc_reg <= '0; j_reg <= '0;
                end
            end
            ST_B_SQS: begin
                sum_reg <= sum_reg + SW'(prod_reg);
                j_reg   <= j_reg + 2'd1;
                sq_x_reg   <= sum_reg + SW'(prod_reg);
                sq_res_reg <= '0;
                sq_bit_reg <= SW'(1) << 62;
            end
            ST_B_SQRT: begin
                // with res still zero a failed step only shifts bit down
                if (sq_bit_reg != 0) begin
                    if (sq_x_reg >= sq_res_reg + sq_bit_reg) begin
                        sq_x_reg   <= sq_x_reg - (sq_res_reg + sq_bit_reg);
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end else begin
                    k_reg <= '0; it_reg <= 7'(DW);
                    dv_num_reg <= DW'(m_reg[0]) << NORM_FRAC;
                    dv_rem_reg <= '0; dv_q_reg <= '0;
                end
            end
            ST_B_DIV: begin
                // restoring division, one quotient bit per cycle
                if (it_reg != 0) begin
                    if ({dv_rem_reg[DW-2:0], dv_num_reg[DW-1]} >= DW'(sq_res_reg)) begin
                        dv_rem_reg <= {dv_rem_reg[DW-2:0], dv_num_reg[DW-1]} - DW'(sq_res_reg);
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b1};
                    end else begin
                        dv_rem_reg <= {dv_rem_reg[DW-2:0], dv_num_reg[DW-1]};
                        dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b0};
                    end
                    dv_num_reg <= dv_num_reg << 1;
                    it_reg     <= it_reg - 7'd1;
                end else begin
                    n_reg[k_reg] <= c_reg[k_reg][CW-1] ? -$signed(dv_q_reg) : $signed(dv_q_reg);
                    k_reg <= k_reg + 2'd1;
                    it_reg <= 7'(DW);
                    dv_num_reg <= DW'(m_reg[(k_reg == 2'd2) ? 2'd2 : k_reg + 2'd1]) << NORM_FRAC;
                    dv_rem_reg <= '0; dv_q_reg <= '0;
                    j_reg <= '0; acc_reg <= '0;
                end
            end
            ST_B_DOTS: begin
                acc_reg <= acc_reg - 67'(prod_sh);
                j_reg   <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
            end
            ST_B_WR: begin
                j_reg <= j_reg + 2'd1;
                if (j_reg == 2'd3) begin
                    pl_reg <= pl_reg + 3'd1; k_reg <= '0; j_reg <= '0;
                end
            end
            ST_T_ACC: begin
                if (k_reg == 2'd3) begin
                    if ($signed(67'(rad_reg)) < acc_reg + 67'($signed(pln_rdata)))
                        inside_reg <= 1'b0;
                    acc_reg <= '0; k_reg <= '0; pl_reg <= pl_reg + 3'd1;
                end else begin
                    acc_reg <= acc_reg + 67'(prod_sh);
                    k_reg   <= k_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_NEVER(a_out_overrun, aclk, aresetn,
        out_vld_reg && !m_tready && state_reg == ST_OUT && state_next == ST_IDLE, "result overwritten")
    `ASSERT_IMPL(a_hold, aclk, aresetn,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped")
    `ASSERT_IMPL(a_ready_idle, aclk, aresetn,
        s_tready |-> (state_reg == ST_IDLE), "ready outside idle")
    `ASSERT_NEVER(a_wr_test, aclk, aresetn,
        pln_we && (act_reg != ACT_BUILD), "plane write outside build")
endmodule
`default_nettype wire
